// ===== sv/pxh_pkg.sv =====
// ----------------------------------------------------------------------------
// pxh_pkg: shared types and constants for the plane position to HSV mapper
// Field widths, color limits, register indexes and the divider cell payload.
// ----------------------------------------------------------------------------
package pxh_pkg;

	localparam int HUE_MAX = 360;
	localparam int SAT_MAX = 255;
	localparam int VAL_MAX = 255;

	localparam int COORD_W = 10;  // column / row
	localparam int DIM_W   = 11;  // plane_width / plane_height
	localparam int HUE_W   = 9;
	localparam int CH_W    = 8;   // saturation / brightness
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 11;

	// divider: quotient bits per item, one cell per bit
	localparam int Q_W     = 9;
	localparam int DIV_W   = 11;
	localparam int HNUM_W  = 19;  // HUE_MAX * row
	localparam int SNUM_W  = 18;  // span * column offset
	localparam int NCELL   = Q_W;

	typedef enum logic [IDX_W-1:0] {
		REG_HUE_TOP       = 3'd0,
		REG_SAT_MIN       = 3'd1,
		REG_VAL_MIN       = 3'd2,
		REG_PLANE_WIDTH   = 3'd3,
		REG_PLANE_HEIGHT  = 3'd4,
		REG_CENTER_COLUMN = 3'd5
	} reg_idx_t;

	// partial state of the two divisions as it moves down the cell row
	// *_nq holds the unconsumed dividend bits on top, quotient bits below
	typedef struct packed {
		logic [DIV_W-1:0] h_rem;
		logic [Q_W-1:0]   h_nq;
		logic [DIV_W-1:0] h_div;
		logic [DIV_W-1:0] s_rem;
		logic [Q_W-1:0]   s_nq;
		logic [DIV_W-1:0] s_div;
		logic             lt;   // column left of center
		logic             gt;   // column right of center
	} cell_t;

endpackage

// ===== sv/pxh_div_cell.sv =====
// ----------------------------------------------------------------------------
// pxh_div_cell: one restoring division step for hue and for sat/val
// Takes one dividend bit per division, emits one quotient bit, registers.
// ----------------------------------------------------------------------------
module pxh_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_i,
	input  pxh_pkg::cell_t cell_i,
	output logic           valid_o,
	output pxh_pkg::cell_t cell_o
);

	logic [pxh_pkg::DIV_W:0]   h_trial;
	logic [pxh_pkg::DIV_W:0]   s_trial;
	logic                      h_ge;
	logic                      s_ge;
	pxh_pkg::cell_t            cell_d;
	logic                      valid_q;
	pxh_pkg::cell_t            cell_q;

	always_comb begin
		h_trial = {cell_i.h_rem, cell_i.h_nq[pxh_pkg::Q_W-1]};
		s_trial = {cell_i.s_rem, cell_i.s_nq[pxh_pkg::Q_W-1]};
		h_ge    = h_trial >= {1'b0, cell_i.h_div};
		s_ge    = s_trial >= {1'b0, cell_i.s_div};

		cell_d       = cell_i;
		cell_d.h_rem = h_ge ? pxh_pkg::DIV_W'(h_trial - {1'b0, cell_i.h_div})
		                    : h_trial[pxh_pkg::DIV_W-1:0];
		cell_d.s_rem = s_ge ? pxh_pkg::DIV_W'(s_trial - {1'b0, cell_i.s_div})
		                    : s_trial[pxh_pkg::DIV_W-1:0];
		cell_d.h_nq  = {cell_i.h_nq[pxh_pkg::Q_W-2:0], h_ge};
		cell_d.s_nq  = {cell_i.s_nq[pxh_pkg::Q_W-2:0], s_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= cell_d;
		end
	end

	assign valid_o = valid_q;
	assign cell_o  = cell_q;

endmodule

// ===== sv/plane_xy_to_hsv.sv =====
// ----------------------------------------------------------------------------
// plane_xy_to_hsv: color plane position to HSV generator
// Clamp, multiply, a row of divider cells, then hue wrap and sat/val finish.
// ----------------------------------------------------------------------------
// Pipeline: 12 registers (2 setup stages, 9 divider cells, 1 output; the
//   first loads at the accepting edge), set by the 9 quotient bits.
// Throughput: one item per cycle while out_ready allows; each stage
//   stalls only when full and blocked, so bubbles collapse and input is
//   taken while a result waits.
// Reset: arst_n clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module plane_xy_to_hsv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [pxh_pkg::IDX_W-1:0]     wr_index,
	input  logic [pxh_pkg::DATA_W-1:0]    wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pxh_pkg::COORD_W-1:0]   column,
	input  logic [pxh_pkg::COORD_W-1:0]   row,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pxh_pkg::HUE_W-1:0]     hue,
	output logic [pxh_pkg::CH_W-1:0]      saturation,
	output logic [pxh_pkg::CH_W-1:0]      brightness
);

	localparam int NC = pxh_pkg::NCELL;

	// configuration
	logic [pxh_pkg::HUE_W-1:0]   hue_top_q;
	logic [pxh_pkg::CH_W-1:0]    sat_min_q;
	logic [pxh_pkg::CH_W-1:0]    val_min_q;
	logic [pxh_pkg::DIM_W-1:0]   width_q;
	logic [pxh_pkg::DIM_W-1:0]   height_q;
	logic [pxh_pkg::COORD_W-1:0] center_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_top_q <= '0;
			sat_min_q <= '0;
			val_min_q <= '0;
			width_q   <= pxh_pkg::DIM_W'(256);
			height_q  <= pxh_pkg::DIM_W'(256);
			center_q  <= pxh_pkg::COORD_W'(128);
		end else if (wr_en) begin
			case (pxh_pkg::reg_idx_t'(wr_index))
				pxh_pkg::REG_HUE_TOP:       hue_top_q <= wr_data[pxh_pkg::HUE_W-1:0];
				pxh_pkg::REG_SAT_MIN:       sat_min_q <= wr_data[pxh_pkg::CH_W-1:0];
				pxh_pkg::REG_VAL_MIN:       val_min_q <= wr_data[pxh_pkg::CH_W-1:0];
				pxh_pkg::REG_PLANE_WIDTH:   width_q   <= wr_data[pxh_pkg::DIM_W-1:0];
				pxh_pkg::REG_PLANE_HEIGHT:  height_q  <= wr_data[pxh_pkg::DIM_W-1:0];
				pxh_pkg::REG_CENTER_COLUMN: center_q  <= wr_data[pxh_pkg::COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// derived config (user changes it only while idle, unchecked here)
	logic [pxh_pkg::DIM_W-1:0] h_eff;
	logic [pxh_pkg::DIM_W-1:0] wm1;
	logic [pxh_pkg::DIM_W-1:0] hm1;
	logic [pxh_pkg::CH_W-1:0]  smin;
	logic [pxh_pkg::CH_W-1:0]  vmin;

	always_comb begin
		h_eff = (height_q == '0) ? pxh_pkg::DIM_W'(1) : height_q;
		hm1   = h_eff - pxh_pkg::DIM_W'(1);
		wm1   = (width_q == '0) ? '0 : width_q - pxh_pkg::DIM_W'(1);
		smin  = (sat_min_q > pxh_pkg::CH_W'(pxh_pkg::SAT_MAX)) ?
		        pxh_pkg::CH_W'(pxh_pkg::SAT_MAX) : sat_min_q;
		vmin  = (val_min_q > pxh_pkg::CH_W'(pxh_pkg::VAL_MAX)) ?
		        pxh_pkg::CH_W'(pxh_pkg::VAL_MAX) : val_min_q;
	end

	// stall chain: a stage loads when empty or when its successor loads
	logic          en_out;
	logic [NC-1:0] en_c;
	logic          en_s2;
	logic          en_s1;
	logic [NC-1:0] v_c;
	logic          v_s1;
	logic          v_s2;

	assign en_out = !out_valid || out_ready;

	always_comb begin
		en_c[NC-1] = !v_c[NC-1] || en_out;
		for (int i = NC - 2; i >= 0; i--) begin
			en_c[i] = !v_c[i] || en_c[i+1];
		end
	end

	assign en_s2    = !v_s2 || en_c[0];
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1: clamp
	logic [pxh_pkg::COORD_W-1:0] x_s1;
	logic [pxh_pkg::COORD_W-1:0] y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1 <= ({1'b0, column} > wm1) ? wm1[pxh_pkg::COORD_W-1:0] : column;
			y_s1 <= ({1'b0, row} > hm1) ? hm1[pxh_pkg::COORD_W-1:0] : row;
		end
	end

	// stage 2: products and divisors
	logic                       lt;
	logic                       gt;
	logic [pxh_pkg::CH_W-1:0]   span;
	logic [pxh_pkg::COORD_W-1:0] offs;
	logic [pxh_pkg::HNUM_W-1:0] h_num;
	logic [pxh_pkg::SNUM_W-1:0] s_num;
	pxh_pkg::cell_t             cell_d;
	pxh_pkg::cell_t             cell_s2;

	always_comb begin
		lt    = x_s1 < center_q;
		gt    = x_s1 > center_q;
		span  = lt ? pxh_pkg::CH_W'(pxh_pkg::SAT_MAX) - smin
		           : pxh_pkg::CH_W'(pxh_pkg::VAL_MAX) - vmin;
		offs  = lt ? x_s1 : x_s1 - center_q;
		h_num = pxh_pkg::HNUM_W'(y_s1) * pxh_pkg::HNUM_W'(pxh_pkg::HUE_MAX);
		s_num = (lt || gt) ? pxh_pkg::SNUM_W'(span) * pxh_pkg::SNUM_W'(offs) : '0;

		cell_d.h_rem = pxh_pkg::DIV_W'(h_num >> pxh_pkg::Q_W);
		cell_d.h_nq  = h_num[pxh_pkg::Q_W-1:0];
		cell_d.h_div = h_eff;
		cell_d.s_rem = pxh_pkg::DIV_W'(s_num >> pxh_pkg::Q_W);
		cell_d.s_nq  = s_num[pxh_pkg::Q_W-1:0];
		// at the center the quotient is unused; divide zero by one
		cell_d.s_div = lt ? {1'b0, center_q}
		             : gt ? wm1 - {1'b0, center_q}
		             : pxh_pkg::DIV_W'(1);
		cell_d.lt    = lt;
		cell_d.gt    = gt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cell_s2 <= cell_d;
		end
	end

	// divider cell row
	pxh_pkg::cell_t cells [NC];

	genvar g;
	generate
		for (g = 0; g < NC; g++) begin : g_cell
			if (g == 0) begin : g_first
				pxh_div_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.en      (en_c[g]),
					.valid_i (v_s2),
					.cell_i  (cell_s2),
					.valid_o (v_c[g]),
					.cell_o  (cells[g])
				);
			end else begin : g_next
				pxh_div_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.en      (en_c[g]),
					.valid_i (v_c[g-1]),
					.cell_i  (cells[g-1]),
					.valid_o (v_c[g]),
					.cell_o  (cells[g])
				);
			end
		end
	endgenerate

	// finish: hue wrap (sum stays below three times HUE_MAX), sat/val
	logic [pxh_pkg::HUE_W:0]  hsum;
	logic [pxh_pkg::HUE_W:0]  hwrap1;
	logic [pxh_pkg::HUE_W:0]  hwrap2;
	logic [pxh_pkg::CH_W-1:0] sq;
	logic [pxh_pkg::CH_W-1:0] sat_d;
	logic [pxh_pkg::CH_W-1:0] val_d;

	always_comb begin
		hsum   = {1'b0, hue_top_q} + {1'b0, cells[NC-1].h_nq};
		hwrap1 = (hsum >= (pxh_pkg::HUE_W+1)'(pxh_pkg::HUE_MAX)) ?
		         hsum - (pxh_pkg::HUE_W+1)'(pxh_pkg::HUE_MAX) : hsum;
		hwrap2 = (hwrap1 >= (pxh_pkg::HUE_W+1)'(pxh_pkg::HUE_MAX)) ?
		         hwrap1 - (pxh_pkg::HUE_W+1)'(pxh_pkg::HUE_MAX) : hwrap1;
		sq     = cells[NC-1].s_nq[pxh_pkg::CH_W-1:0];
		sat_d  = cells[NC-1].lt ? smin + sq : pxh_pkg::CH_W'(pxh_pkg::SAT_MAX);
		val_d  = cells[NC-1].gt ? pxh_pkg::CH_W'(pxh_pkg::VAL_MAX) - sq
		                        : pxh_pkg::CH_W'(pxh_pkg::VAL_MAX);
	end

	logic                      out_valid_q;
	logic [pxh_pkg::HUE_W-1:0] hue_q;
	logic [pxh_pkg::CH_W-1:0]  sat_q;
	logic [pxh_pkg::CH_W-1:0]  val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_c[NC-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_c[NC-1]) begin
			hue_q <= hwrap2[pxh_pkg::HUE_W-1:0];
			sat_q <= sat_d;
			val_q <= val_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = val_q;

endmodule

// ===== sv/pxh_checker.sv =====
// ----------------------------------------------------------------------------
// pxh_checker: port-level checks for plane_xy_to_hsv
// Output hold, hue range, reset and back-pressure behavior.
// ----------------------------------------------------------------------------
module pxh_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [pxh_pkg::HUE_W-1:0] hue,
	input logic [pxh_pkg::CH_W-1:0]  saturation,
	input logic [pxh_pkg::CH_W-1:0]  brightness
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(hue) && $stable(saturation) && $stable(brightness))
		else $error("result changed while stalled");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue < pxh_pkg::HUE_W'(pxh_pkg::HUE_MAX))
		else $error("hue out of range");

	// an edge seen in reset has cleared the output by the next one
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown during reset");

	// with the output free the whole pipe advances
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with output free");

	a_idle_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid && in_ready)
		else $error("not idle after reset");

endmodule

bind plane_xy_to_hsv pxh_checker u_pxh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hue        (hue),
	.saturation (saturation),
	.brightness (brightness)
);
